FILE: rtl/bcum_pkg.sv
// ----------------------------------------------------------------------------
// bcum_pkg: shared types for the binned color usage map
// Op codes, register indexes, controller states and the command and status
// groups passed between controller and datapath.
// ----------------------------------------------------------------------------
package bcum_pkg;

  localparam int unsigned CNT_W     = 48;  // count and cluster width
  localparam int unsigned CFG_IDX_W = 3;   // config register index width

  typedef enum logic [1:0] {
    OP_FILL  = 2'd0,
    OP_COLOR = 2'd1,
    OP_READ  = 2'd2,
    OP_BAD   = 2'd3
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TOTAL  = 3'd0,
    REG_CELLS  = 3'd1,
    REG_REV    = 3'd2,
    REG_CPC    = 3'd3,
    REG_LAST   = 3'd4,
    REG_CPCL   = 3'd5,
    REG_UNUSED = 3'd6
  } reg_e;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_CHECK, S_FILL, S_DIV, S_DIVW, S_NSTEP, S_NMOD,
    S_MUL1, S_MUL2, S_RCHK, S_RRD, S_RWR, S_RD, S_RESULT
  } state_e;

  typedef enum logic [3:0] {
    DP_NONE, DP_CLEAR, DP_CHECK, DP_FILL, DP_DIV, DP_DIVW, DP_NSTEP, DP_NMOD,
    DP_MUL1, DP_MUL2, DP_RCHK, DP_RRD, DP_RWR, DP_RD, DP_RESULT
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
    logic   take;   // input channel ready
  } dp_cmd_t;

  typedef struct packed {
    logic in_valid;
    op_e  op;
    logic chk_reject;
    logic chk_noop;
    logic rev;
    logic sweep_last;
    logic div_done;
    logic div_bad;
    logic rchk_bad;
    logic rchk_empty;
    logic walk_last;
    logic rev_last;
    logic out_free;
  } dp_sts_t;

endpackage

FILE: rtl/bcum_if.sv
// ----------------------------------------------------------------------------
// bcum interfaces: request, result and config channels
// Valid/ready channels; an item moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface bcum_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [47:0] start_cluster;
  logic [47:0] region_length;
  logic [3:0]  dst_color;
  logic [3:0]  src_color;
  logic [9:0]  read_cell;
  logic [3:0]  read_color;

  modport source (output valid, op, start_cluster, region_length, dst_color,
                  src_color, read_cell, read_color, input ready);
  modport sink   (input valid, op, start_cluster, region_length, dst_color,
                  src_color, read_cell, read_color, output ready);
endinterface

interface bcum_out_if;
  logic        valid;
  logic        ready;
  logic [47:0] count_value;
  logic        status;

  modport source (output valid, count_value, status, input ready);
  modport sink   (input valid, count_value, status, output ready);
endinterface

interface bcum_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [47:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/bcum_div.sv
// ----------------------------------------------------------------------------
// bcum_div: iterative restoring divider
// One quotient bit per cycle.
// ----------------------------------------------------------------------------
module bcum_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [bcum_pkg::CNT_W-1:0] dividend_i,
  input  logic [bcum_pkg::CNT_W-1:0] divisor_i,
  output logic                       done_o,
  output logic [bcum_pkg::CNT_W-1:0] quot_o,
  output logic [bcum_pkg::CNT_W-1:0] rem_o
);
  import bcum_pkg::*;

  localparam int unsigned STEP_W = $clog2(CNT_W);

  logic              busy_q, done_q;
  logic [STEP_W-1:0] step_q;
  logic [CNT_W-1:0]  quot_q, rem_q;
  logic [CNT_W:0]    trial, diff;
  logic              ge;

  // shift in the next dividend bit and try a subtract
  assign trial = {rem_q, quot_q[CNT_W-1]};
  assign diff  = trial - {1'b0, divisor_i};
  assign ge    = trial >= {1'b0, divisor_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      step_q <= '0;
    end else if (busy_q) begin
      step_q <= step_q + 1'b1;
      if (step_q == STEP_W'(CNT_W - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quot_q <= dividend_i;
      rem_q  <= '0;
    end else if (busy_q) begin
      quot_q <= {quot_q[CNT_W-2:0], ge};
      rem_q  <= ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;
  assign rem_o  = rem_q;

endmodule

FILE: rtl/bcum_dp.sv
// ----------------------------------------------------------------------------
// bcum_dp: datapath of the color usage map
// Config registers, request latch, range checks, divider, multiplier, the
// row-wide count memory and the result register.
// ----------------------------------------------------------------------------
module bcum_dp #(
  parameter int unsigned MAX_CELLS    = 1024,
  parameter int unsigned NUM_COLORS   = 16,
  parameter int unsigned ZONE_COLOR   = 15,
  parameter int unsigned FILL_COLOR   = 0,
  parameter int unsigned UNUSED_COLOR = 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  bcum_in_if.sink           in_if,
  bcum_out_if.source        out_if,
  bcum_cfg_if.sink          cfg_if,
  input  bcum_pkg::dp_cmd_t cmd_i,
  output bcum_pkg::dp_sts_t sts_o
);
  import bcum_pkg::*;

  localparam int unsigned AW = $clog2(MAX_CELLS);
  localparam int unsigned CW = $clog2(NUM_COLORS);
  localparam bit DEF_OK = (FILL_COLOR < NUM_COLORS) && (UNUSED_COLOR < NUM_COLORS);
  localparam int unsigned FILL_IDX   = DEF_OK ? FILL_COLOR : 0;
  localparam int unsigned UNUSED_IDX = DEF_OK ? UNUSED_COLOR : 0;

  typedef logic [NUM_COLORS-1:0][CNT_W-1:0] row_t;

  // config registers
  logic [CNT_W-1:0] tc_q, cpc_q, lcl_q;
  logic [10:0]      ciu_q, cpcl_q;
  logic             rev_q;
  logic [9:0]       ucc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tc_q   <= CNT_W'(1);
      ciu_q  <= 11'd1024;
      rev_q  <= 1'b0;
      cpc_q  <= CNT_W'(1);
      lcl_q  <= CNT_W'(1);
      cpcl_q <= '0;
      ucc_q  <= '0;
    end else if (cfg_if.valid) begin
      unique case (reg_e'(cfg_if.index))
        REG_TOTAL:  tc_q   <= cfg_if.data;
        REG_CELLS:  ciu_q  <= cfg_if.data[10:0];
        REG_REV:    rev_q  <= cfg_if.data[0];
        REG_CPC:    cpc_q  <= cfg_if.data;
        REG_LAST:   lcl_q  <= cfg_if.data;
        REG_CPCL:   cpcl_q <= cfg_if.data[10:0];
        REG_UNUSED: ucc_q  <= cfg_if.data[9:0];
        default: ;
      endcase
    end
  end

  assign cfg_if.ready = 1'b1;

  // request latch
  op_e              op_q;
  logic [CNT_W-1:0] lcn_q, len_q;
  logic [3:0]       nc_q, oc_q, rk_q;
  logic [9:0]       rc_q;

  assign in_if.ready = cmd_i.take;

  always_ff @(posedge clk_i) begin
    if (cmd_i.take && in_if.valid) begin
      op_q  <= op_e'(in_if.op);
      lcn_q <= in_if.start_cluster;
      nc_q  <= in_if.dst_color;
      oc_q  <= in_if.src_color;
      rc_q  <= in_if.read_cell;
      rk_q  <= in_if.read_color;
    end
  end

  // request checks
  logic cells_ok, zone, nc_bad, oc_bad, range_bad, pre_bad, noop, reject;
  logic [CNT_W:0] end_sum;

  assign cells_ok  = (ciu_q != '0) && (32'(ciu_q) <= MAX_CELLS);
  assign zone      = 32'(nc_q) == ZONE_COLOR;
  assign nc_bad    = 32'(nc_q) >= NUM_COLORS;
  assign oc_bad    = 32'(oc_q) >= NUM_COLORS;
  assign end_sum   = {1'b0, lcn_q} + {1'b0, len_q};
  assign range_bad = (lcn_q >= tc_q) || (end_sum > {1'b0, tc_q});
  assign pre_bad   = !cells_ok || range_bad || nc_bad || (!zone && oc_bad);
  assign noop      = (len_q == '0) || (nc_q == oc_q);

  always_comb begin
    case (op_q)
      OP_FILL:  reject = !cells_ok ||
                         (rev_q ? (11'(ucc_q) > ciu_q) : (11'(ucc_q) >= ciu_q));
      OP_COLOR: reject = pre_bad || (!noop && !rev_q && (cpc_q == '0));
      OP_READ:  reject = (32'(rc_q) >= 32'(ciu_q)) || (32'(rc_q) >= MAX_CELLS) ||
                         (32'(rk_q) >= NUM_COLORS);
      default:  reject = 1'b1;
    endcase
  end

  // divider for first cell and offset
  logic             div_done;
  logic [CNT_W-1:0] quot, rem;

  bcum_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.op == DP_DIV),
    .dividend_i (lcn_q),
    .divisor_i  (cpc_q),
    .done_o     (div_done),
    .quot_o     (quot),
    .rem_o      (rem)
  );

  // reversed mode cell range
  logic [CNT_W-1:0] mul_a;
  logic [58:0]      prod, first_q, cnt_q;
  logic [59:0]      rev_end;

  assign mul_a   = (cmd_i.op == DP_MUL1) ? lcn_q : len_q;
  assign prod    = {11'd0, mul_a} * {48'd0, cpcl_q};
  assign rev_end = {1'b0, first_q} + {1'b0, cnt_q};

  // walk state
  logic [AW-1:0]    cell_q, sw_q;
  logic [AW:0]      rcnt_q;
  logic [CNT_W-1:0] off_q, n_q, room, n_d;
  logic             not_last;

  assign not_last = (32'(cell_q) + 1) < 32'(ciu_q);

  always_comb begin
    if (not_last) begin
      room = cpc_q - off_q;
    end else begin
      room = (lcl_q > off_q) ? (lcl_q - off_q) : '0;
    end
    n_d = (len_q < room) ? len_q : room;
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      DP_DIVW: if (div_done) begin
        cell_q <= AW'(quot);
        off_q  <= rem;
      end
      DP_NSTEP: n_q <= n_d;
      DP_NMOD: begin
        len_q  <= len_q - n_q;
        cell_q <= cell_q + 1'b1;
        off_q  <= '0;
      end
      DP_MUL1: first_q <= prod;
      DP_MUL2: cnt_q   <= prod;
      DP_RCHK: begin
        cell_q <= first_q[AW-1:0];
        rcnt_q <= cnt_q[AW:0];
      end
      DP_RWR: begin
        cell_q <= cell_q + 1'b1;
        rcnt_q <= rcnt_q - 1'b1;
      end
      default: ;
    endcase
    if (cmd_i.take && in_if.valid) begin
      len_q <= in_if.region_length;
    end
  end

  // refill row for the sweep
  logic [10:0] used;
  row_t        fill_row;

  assign used = ciu_q - 11'(ucc_q);

  always_comb begin
    fill_row = '0;
    if (cmd_i.op == DP_FILL && DEF_OK) begin
      if (32'(sw_q) < 32'(used)) begin
        if (rev_q) begin
          fill_row[FILL_IDX] = CNT_W'(1);
        end else if ((32'(sw_q) + 1) < 32'(used)) begin
          fill_row[FILL_IDX] = cpc_q;
        end else begin
          fill_row[FILL_IDX] = lcl_q;
        end
      end else if (32'(sw_q) < 32'(ciu_q)) begin
        fill_row[UNUSED_IDX] = rev_q ? CNT_W'(1) : cpc_q;
      end
    end
  end

  // sweep counter, shared by reset clear and refill
  logic sweep, sweep_last;

  assign sweep      = (cmd_i.op == DP_CLEAR) || (cmd_i.op == DP_FILL);
  assign sweep_last = sw_q == AW'(MAX_CELLS - 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sw_q <= '0;
    end else if (sweep) begin
      sw_q <= sweep_last ? '0 : sw_q + 1'b1;
    end
  end

  // row modify
  logic [CW-1:0] nc_idx, oc_idx;
  logic [CNT_W:0] add_sum;
  row_t           rd_q, mod_row, rev_row, wr_row;

  assign nc_idx  = CW'(nc_q);
  assign oc_idx  = CW'(oc_q);
  assign add_sum = {1'b0, rd_q[nc_idx]} + {1'b0, n_q};

  always_comb begin
    mod_row = rd_q;
    mod_row[nc_idx] = add_sum[CNT_W] ? '1 : add_sum[CNT_W-1:0];
    if (!zone) begin
      mod_row[oc_idx] = (rd_q[oc_idx] >= n_q) ? (rd_q[oc_idx] - n_q) : '0;
    end
    rev_row = zone ? rd_q : '0;
    rev_row[nc_idx] = CNT_W'(1);
  end

  // count memory, one row of colors per cell
  row_t          mem [MAX_CELLS];
  logic          we, re;
  logic [AW-1:0] wa, ra;

  always_comb begin
    we = 1'b0;
    wa = cell_q;
    wr_row = mod_row;
    case (cmd_i.op)
      DP_CLEAR, DP_FILL: begin
        we = 1'b1;
        wa = sw_q;
        wr_row = fill_row;
      end
      DP_NMOD: we = 1'b1;
      DP_RWR: begin
        we = 1'b1;
        wr_row = rev_row;
      end
      default: ;
    endcase
  end

  assign re = (cmd_i.op == DP_NSTEP) || (cmd_i.op == DP_RRD) || (cmd_i.op == DP_RD);
  assign ra = (cmd_i.op == DP_RD) ? AW'(rc_q) : cell_q;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wa] <= wr_row;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re) begin
      rd_q <= mem[ra];
    end
  end

  // reject flag and result register
  logic             fail_q, out_valid_q, out_free, div_bad, rchk_bad;
  logic [CNT_W-1:0] cnt_out_q;
  logic             status_q;

  assign div_bad  = quot >= CNT_W'(ciu_q);
  assign rchk_bad = rev_end > 60'(ciu_q);
  assign out_free = !out_valid_q || out_if.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fail_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      case (cmd_i.op)
        DP_CHECK: fail_q <= reject;
        DP_DIVW:  if (div_done) fail_q <= div_bad;
        DP_RCHK:  fail_q <= rchk_bad;
        default: ;
      endcase
      if (cmd_i.op == DP_RESULT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == DP_RESULT && out_free) begin
      cnt_out_q <= (op_q == OP_READ && !fail_q) ? rd_q[CW'(rk_q)] : '0;
      status_q  <= fail_q;
    end
  end

  assign out_if.valid       = out_valid_q;
  assign out_if.count_value = cnt_out_q;
  assign out_if.status      = status_q;

  // status to controller
  always_comb begin
    sts_o.in_valid   = in_if.valid;
    sts_o.op         = op_q;
    sts_o.chk_reject = reject;
    sts_o.chk_noop   = noop;
    sts_o.rev        = rev_q;
    sts_o.sweep_last = sweep_last;
    sts_o.div_done   = div_done;
    sts_o.div_bad    = div_bad;
    sts_o.rchk_bad   = rchk_bad;
    sts_o.rchk_empty = cnt_q == '0;
    sts_o.walk_last  = !not_last || (len_q == n_q);
    sts_o.rev_last   = rcnt_q == (AW+1)'(1);
    sts_o.out_free   = out_free;
  end

endmodule

FILE: rtl/bcum_ctrl.sv
// ----------------------------------------------------------------------------
// bcum_ctrl: controller of the color usage map
// Sequences reset clear, checks, refill sweep, cell walks and result hand-off.
// ----------------------------------------------------------------------------
module bcum_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  bcum_pkg::dp_sts_t sts_i,
  output bcum_pkg::dp_cmd_t cmd_o
);
  import bcum_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLEAR:  if (sts_i.sweep_last) state_d = S_IDLE;
      S_IDLE:   if (sts_i.in_valid) state_d = S_CHECK;
      S_CHECK: begin
        if (sts_i.chk_reject) begin
          state_d = S_RESULT;
        end else begin
          unique case (sts_i.op)
            OP_FILL:  state_d = S_FILL;
            OP_COLOR: state_d = sts_i.chk_noop ? S_RESULT : (sts_i.rev ? S_MUL1 : S_DIV);
            OP_READ:  state_d = S_RD;
            default:  state_d = S_RESULT;
          endcase
        end
      end
      S_FILL:   if (sts_i.sweep_last) state_d = S_RESULT;
      S_DIV:    state_d = S_DIVW;
      S_DIVW:   if (sts_i.div_done) state_d = sts_i.div_bad ? S_RESULT : S_NSTEP;
      S_NSTEP:  state_d = S_NMOD;
      S_NMOD:   state_d = sts_i.walk_last ? S_RESULT : S_NSTEP;
      S_MUL1:   state_d = S_MUL2;
      S_MUL2:   state_d = S_RCHK;
      S_RCHK:   state_d = (sts_i.rchk_bad || sts_i.rchk_empty) ? S_RESULT : S_RRD;
      S_RRD:    state_d = S_RWR;
      S_RWR:    state_d = sts_i.rev_last ? S_RESULT : S_RRD;
      S_RD:     state_d = S_RESULT;
      S_RESULT: if (sts_i.out_free) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  // datapath commands
  always_comb begin
    cmd_o.take = 1'b0;
    cmd_o.op   = DP_NONE;
    unique case (state_q)
      S_CLEAR:  cmd_o.op = DP_CLEAR;
      S_IDLE:   cmd_o.take = 1'b1;
      S_CHECK:  cmd_o.op = DP_CHECK;
      S_FILL:   cmd_o.op = DP_FILL;
      S_DIV:    cmd_o.op = DP_DIV;
      S_DIVW:   cmd_o.op = DP_DIVW;
      S_NSTEP:  cmd_o.op = DP_NSTEP;
      S_NMOD:   cmd_o.op = DP_NMOD;
      S_MUL1:   cmd_o.op = DP_MUL1;
      S_MUL2:   cmd_o.op = DP_MUL2;
      S_RCHK:   cmd_o.op = DP_RCHK;
      S_RRD:    cmd_o.op = DP_RRD;
      S_RWR:    cmd_o.op = DP_RWR;
      S_RD:     cmd_o.op = DP_RD;
      S_RESULT: cmd_o.op = DP_RESULT;
      default:  cmd_o.op = DP_NONE;
    endcase
  end

endmodule

FILE: rtl/binned_color_usage_map_core.sv
// ----------------------------------------------------------------------------
// binned_color_usage_map_core: per-cell, per-color cluster count table
//
//   channel  dir  handshake     payload
//   in_i     in   valid/ready   op, start_cluster, region_length, colors, read
//   out_o    out  valid/ready   count_value, status
//   cfg_i    in   valid/ready   index, data (always ready)
//
// One item at a time. Refill sweeps all MAX_CELLS rows. Colorize in normal
// mode first runs the 48-step divider, then for each cell touched does a
// memory read, then a modify and write; reversed mode also reads and then
// writes each cell. After reset a clearing pass over all MAX_CELLS rows
// runs before the first item is taken. A stalled result holds the next one back.
// ----------------------------------------------------------------------------
module binned_color_usage_map_core #(
  parameter int unsigned MAX_CELLS    = 1024,
  parameter int unsigned NUM_COLORS   = 16,
  parameter int unsigned ZONE_COLOR   = 15,
  parameter int unsigned FILL_COLOR   = 0,
  parameter int unsigned UNUSED_COLOR = 1
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  bcum_in_if.sink    in_i,
  bcum_out_if.source out_o,
  bcum_cfg_if.sink   cfg_i
);
  import bcum_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  bcum_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  bcum_dp #(
    .MAX_CELLS    (MAX_CELLS),
    .NUM_COLORS   (NUM_COLORS),
    .ZONE_COLOR   (ZONE_COLOR),
    .FILL_COLOR   (FILL_COLOR),
    .UNUSED_COLOR (UNUSED_COLOR)
  ) u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (in_i),
    .out_if (out_o),
    .cfg_if (cfg_i),
    .cmd_i  (cmd),
    .sts_o  (sts)
  );

endmodule

FILE: tb/sv/tb_binned_color_usage_map_core.sv
// ----------------------------------------------------------------------------
// tb_binned_color_usage_map_core: self-checking bench for the color usage map
// Drives refill, colorize, read and bad op items over several register settings,
// predicts every result with a local copy of the count table and compares
// each returned item field by field. Sender and receiver idle at random.
// ----------------------------------------------------------------------------
module tb_binned_color_usage_map_core;
  timeunit 1ns;
  timeprecision 1ps;
  import bcum_pkg::*;

  localparam int unsigned NCELL  = 1024;
  localparam int unsigned NCOLOR = 16;
  localparam int unsigned ZONE   = 15;
  localparam int unsigned FILLC  = 0;
  localparam int unsigned UNUSEDC = 1;
  localparam logic [47:0] SAT48  = 48'hFFFF_FFFF_FFFF;
  localparam int unsigned STALL_LIMIT = 400000;

  typedef struct {
    op_e         op;
    logic [47:0] start_cluster;
    logic [47:0] region_length;
    logic [3:0]  dst_color;
    logic [3:0]  src_color;
    logic [9:0]  read_cell;
    logic [3:0]  read_color;
  } req_t;

  typedef struct {
    logic [47:0] count_value;
    logic        status;
  } rsp_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  bcum_in_if  req_ch();
  bcum_out_if rsp_ch();
  bcum_cfg_if cfg_ch();

  binned_color_usage_map_core dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (req_ch.sink),
    .out_o (rsp_ch.source),
    .cfg_i (cfg_ch.sink)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // predictor state
  logic [47:0] counts [NCELL*NCOLOR];
  logic [47:0] r_total, r_cpc, r_last;
  logic [10:0] r_cells, r_cpcl;
  logic        r_rev;
  logic [9:0]  r_unused;

  req_t pending_reqs[$];
  rsp_t expected_rsps[$];
  int   errors = 0;
  int   send_idle = 0;   // percent
  int   recv_stall = 0;  // percent
  bit   hold_off = 0;
  int   quiet_cycles = 0;

  function automatic logic [47:0] sat_add(logic [47:0] a, logic [63:0] n);
    logic [63:0] s;
    s = {16'd0, a} + n;
    return (s > {16'd0, SAT48}) ? SAT48 : s[47:0];
  endfunction

  function automatic logic [47:0] sat_sub(logic [47:0] a, logic [63:0] n);
    return ({16'd0, a} >= n) ? a - n[47:0] : 48'd0;
  endfunction

  function automatic void shift_clusters(int unsigned cix, int unsigned nc, int unsigned oc,
                                         logic [63:0] n);
    counts[cix*NCOLOR+nc] = sat_add(counts[cix*NCOLOR+nc], n);
    if (nc != ZONE) counts[cix*NCOLOR+oc] = sat_sub(counts[cix*NCOLOR+oc], n);
  endfunction

  function automatic logic apply_refill();
    int unsigned used;
    if (r_cells < 1 || r_cells > NCELL) return 1'b1;
    if (!r_rev && r_unused >= r_cells) return 1'b1;
    if (r_rev && r_unused > r_cells) return 1'b1;
    foreach (counts[i]) counts[i] = '0;
    used = r_cells - r_unused;
    if (!r_rev) begin
      for (int unsigned i = 0; i + 1 < used; i++) counts[i*NCOLOR+FILLC] = r_cpc;
      counts[(used-1)*NCOLOR+FILLC] = r_last;
      for (int unsigned i = used; i < r_cells; i++) counts[i*NCOLOR+UNUSEDC] = r_cpc;
    end else begin
      for (int unsigned i = 0; i < used; i++) counts[i*NCOLOR+FILLC] = 48'd1;
      for (int unsigned i = used; i < r_cells; i++) counts[i*NCOLOR+UNUSEDC] = 48'd1;
    end
    return 1'b0;
  endfunction

  function automatic logic apply_colorize(req_t r);
    logic [63:0] lcn, len, cix, offs, room, n, first, cnt;
    int unsigned nc, oc;
    lcn = r.start_cluster;
    len = r.region_length;
    nc = r.dst_color;
    oc = r.src_color;
    if (r_cells < 1 || r_cells > NCELL) return 1'b1;
    if (lcn >= r_total || lcn + len > r_total) return 1'b1;
    if (nc >= NCOLOR) return 1'b1;
    if (nc != ZONE && oc >= NCOLOR) return 1'b1;
    if (len == 0 || nc == oc) return 1'b0;
    if (!r_rev) begin
      if (r_cpc == 0) return 1'b1;
      cix = lcn / r_cpc;
      if (cix >= r_cells) return 1'b1;
      offs = lcn % r_cpc;
      while (cix + 1 < r_cells && len != 0) begin
        room = r_cpc - offs;
        n = (len < room) ? len : room;
        shift_clusters(32'(cix), nc, oc, n);
        len -= n;
        cix++;
        offs = 0;
      end
      if (len != 0) begin
        room = (r_last > offs) ? r_last - offs : 0;
        n = (len < room) ? len : room;
        shift_clusters(32'(cix), nc, oc, n);
      end
    end else begin
      first = lcn * r_cpcl;
      cnt = len * r_cpcl;
      if (first + cnt > r_cells) return 1'b1;
      for (longint unsigned i = 0; i < cnt; i++) begin
        if (nc != ZONE)
          for (int unsigned j = 0; j < NCOLOR; j++) counts[(first+i)*NCOLOR+j] = '0;
        counts[(first+i)*NCOLOR+nc] = 48'd1;
      end
    end
    return 1'b0;
  endfunction

  function automatic rsp_t predict_map(req_t r);
    rsp_t e;
    e.count_value = '0;
    case (r.op)
      OP_FILL:  e.status = apply_refill();
      OP_COLOR: e.status = apply_colorize(r);
      OP_READ: begin
        if (r.read_cell >= r_cells || r.read_color >= NCOLOR) e.status = 1'b1;
        else begin
          e.count_value = counts[r.read_cell*NCOLOR+r.read_color];
          e.status = 1'b0;
        end
      end
      default: e.status = 1'b1;
    endcase
    return e;
  endfunction

  task automatic report_mismatch(string what, logic [47:0] got, logic [47:0] want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // request driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_ch.valid <= 1'b0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        req_t q;
        q.op = op_e'(req_ch.op);
        q.start_cluster = req_ch.start_cluster;
        q.region_length = req_ch.region_length;
        q.dst_color = req_ch.dst_color;
        q.src_color = req_ch.src_color;
        q.read_cell = req_ch.read_cell;
        q.read_color = req_ch.read_color;
        expected_rsps.push_back(predict_map(q));
      end
      if ((!req_ch.valid || req_ch.ready)) begin
        if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle) begin
          req_t r;
          r = pending_reqs.pop_front();
          req_ch.valid <= 1'b1;
          req_ch.op <= r.op;
          req_ch.start_cluster <= r.start_cluster;
          req_ch.region_length <= r.region_length;
          req_ch.dst_color <= r.dst_color;
          req_ch.src_color <= r.src_color;
          req_ch.read_cell <= r.read_cell;
          req_ch.read_color <= r.read_color;
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor and ready generation
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (expected_rsps.size() == 0) begin
          report_mismatch("unexpected item", rsp_ch.count_value, 48'd0);
        end else begin
          rsp_t e;
          e = expected_rsps.pop_front();
          if (rsp_ch.count_value !== e.count_value)
            report_mismatch("count_value", rsp_ch.count_value, e.count_value);
          if (rsp_ch.status !== e.status)
            report_mismatch("status", {47'd0, rsp_ch.status}, {47'd0, e.status});
        end
      end
      rsp_ch.ready <= !hold_off && ($urandom_range(99) >= recv_stall);
    end
  end

  // watchdog on accepted items
  always @(posedge clk_i) begin
    if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
        || cfg_ch.valid || !rst_ni || hold_off)
      quiet_cycles <= 0;
    else if (pending_reqs.size() > 0 || expected_rsps.size() > 0 || req_ch.valid)
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb_binned_color_usage_map_core: FAIL");
      $finish;
    end
  end

  task automatic write_reg(reg_e idx, logic [47:0] val);
    @(posedge clk_i);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= val;
    do @(posedge clk_i); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    case (idx)
      REG_TOTAL:  r_total = val;
      REG_CELLS:  r_cells = val[10:0];
      REG_REV:    r_rev = val[0];
      REG_CPC:    r_cpc = val;
      REG_LAST:   r_last = val;
      REG_CPCL:   r_cpcl = val[10:0];
      REG_UNUSED: r_unused = val[9:0];
      default: ;
    endcase
  endtask

  task automatic drain();
    while (pending_reqs.size() > 0 || req_ch.valid || expected_rsps.size() > 0)
      @(posedge clk_i);
    repeat (NCELL + 100) @(posedge clk_i);
  endtask

  function automatic req_t make_req(op_e op, logic [47:0] sc, logic [47:0] len,
                                    logic [3:0] nc, logic [3:0] oc,
                                    logic [9:0] rcell, logic [3:0] col);
    req_t r;
    r.op = op; r.start_cluster = sc; r.region_length = len;
    r.dst_color = nc; r.src_color = oc; r.read_cell = rcell; r.read_color = col;
    return r;
  endfunction

  function automatic logic [47:0] rand48();
    return 48'({$urandom(), $urandom()} >> $urandom_range(47));
  endfunction

  // random item biased toward valid ranges of the current geometry
  function automatic req_t random_req();
    req_t r;
    int unsigned k;
    logic [47:0] sc, len;
    k = $urandom_range(99);
    if (k < 92 && r_total != 0) begin
      if (r_total <= 48'hFFFF_FFFF) sc = 48'($urandom_range(32'(r_total - 48'd1)));
      else sc = rand48() % r_total;
      len = r_total - sc;
      if ($urandom_range(3) != 0) begin
        if (len <= 48'hFFFF_FFFF) len = 48'($urandom_range(32'(len)));
        else len = 48'({16'd0, rand48()} % ({16'd0, len} + 64'd1));
      end
    end else begin
      sc = rand48(); len = rand48();
    end
    r = make_req(OP_COLOR, sc, len, 4'($urandom_range(15)), 4'($urandom_range(15)),
                 10'($urandom_range(1023)), 4'($urandom_range(15)));
    if ($urandom_range(5) == 0) r.dst_color = 4'(ZONE);
    if ($urandom_range(3) == 0)
      r.read_cell = 10'($urandom_range(r_cells > 0 ? 32'(r_cells) - 1 : 0));
    k = $urandom_range(99);
    if (k < 3) r.op = OP_FILL;
    else if (k < 48) r.op = OP_READ;
    else if (k < 50) r.op = OP_BAD;
    return r;
  endfunction

  task automatic run_phase(int n, int idle, int stall);
    send_idle = idle;
    recv_stall = stall;
    pending_reqs.push_back(make_req(OP_FILL, 0, 0, 0, 0, 0, 0));
    for (int i = 0; i < n; i++) pending_reqs.push_back(random_req());
    drain();
  endtask

  initial begin
    cfg_ch.valid = 1'b0; cfg_ch.index = '0; cfg_ch.data = '0;
    req_ch.valid = 1'b0; req_ch.op = '0; req_ch.start_cluster = '0;
    req_ch.region_length = '0; req_ch.dst_color = '0; req_ch.src_color = '0;
    req_ch.read_cell = '0; req_ch.read_color = '0;
    rsp_ch.ready = 1'b0;
    foreach (counts[i]) counts[i] = '0;
    r_total = 1; r_cells = 1024; r_rev = 0; r_cpc = 1; r_last = 1;
    r_cpcl = 0; r_unused = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: items at reset defaults, then a small normal geometry
    pending_reqs.push_back(make_req(OP_READ, 0, 0, 0, 0, 10'd1023, 4'd15));
    pending_reqs.push_back(make_req(OP_COLOR, 0, 1, 2, 0, 0, 0));
    pending_reqs.push_back(make_req(OP_BAD, 0, 0, 0, 0, 0, 0));
    drain();
    write_reg(REG_TOTAL, 48'd1000);
    write_reg(REG_CELLS, 11'd10);
    write_reg(REG_CPC, 48'd110);
    write_reg(REG_LAST, 48'd10);
    write_reg(REG_UNUSED, 10'd0);
    pending_reqs.push_back(make_req(OP_FILL, 0, 0, 0, 0, 0, 0));
    pending_reqs.push_back(make_req(OP_COLOR, 105, 300, 3, 0, 0, 0));
    pending_reqs.push_back(make_req(OP_COLOR, 990, 10, 15, 9, 0, 0));
    pending_reqs.push_back(make_req(OP_COLOR, 0, 0, 3, 0, 0, 0));
    pending_reqs.push_back(make_req(OP_COLOR, 5, 5, 4, 4, 0, 0));
    pending_reqs.push_back(make_req(OP_COLOR, 1000, 1, 3, 0, 0, 0));
    pending_reqs.push_back(make_req(OP_COLOR, 999, 2, 3, 0, 0, 0));
    pending_reqs.push_back(make_req(OP_COLOR, 0, 1000, 2, 7, 0, 0));
    pending_reqs.push_back(make_req(OP_COLOR, 0, 5, 15, 15, 0, 0));
    pending_reqs.push_back(make_req(OP_READ, 0, 0, 0, 0, 10'd1, 4'd3));
    pending_reqs.push_back(make_req(OP_READ, 0, 0, 0, 0, 10'd9, 4'd0));
    pending_reqs.push_back(make_req(OP_READ, 0, 0, 0, 0, 10'd10, 4'd0));
    pending_reqs.push_back(make_req(OP_READ, 0, 0, 0, 0, 10'd9, 4'd15));
    drain();
    write_reg(REG_UNUSED, 10'd10);   // unused equal to cells: refill rejected
    pending_reqs.push_back(make_req(OP_FILL, 0, 0, 0, 0, 0, 0));
    drain();
    write_reg(REG_CPC, 48'd0);       // zero clusters per cell rejects colorize
    write_reg(REG_UNUSED, 10'd3);
    pending_reqs.push_back(make_req(OP_COLOR, 1, 1, 1, 0, 0, 0));
    drain();
    write_reg(REG_CELLS, 11'd0);     // bad cell count
    pending_reqs.push_back(make_req(OP_FILL, 0, 0, 0, 0, 0, 0));
    pending_reqs.push_back(make_req(OP_COLOR, 0, 1, 1, 0, 0, 0));
    drain();

    // normal mode, no idling, with saturation-sized counts
    write_reg(REG_CELLS, 11'd64);
    write_reg(REG_TOTAL, SAT48);
    write_reg(REG_CPC, 48'h0400_0000_0000);
    write_reg(REG_LAST, SAT48);
    write_reg(REG_UNUSED, 10'd2);
    run_phase(120, 0, 0);

    // normal mode, sender idling; small cells
    write_reg(REG_CELLS, 11'd32);
    write_reg(REG_TOTAL, 48'd300);
    write_reg(REG_CPC, 48'd10);
    write_reg(REG_LAST, 48'd7);
    write_reg(REG_UNUSED, 10'd0);
    run_phase(120, 78, 0);

    // long receiver hold-off while items keep coming
    hold_off = 1;
    send_idle = 0;
    for (int i = 0; i < 20; i++) pending_reqs.push_back(random_req());
    repeat (3000) @(posedge clk_i);
    hold_off = 0;
    drain();

    // reversed mode, receiver stalling
    write_reg(REG_REV, 1'b1);
    write_reg(REG_CELLS, 11'd1024);
    write_reg(REG_CPCL, 11'd4);
    write_reg(REG_TOTAL, 48'd256);
    write_reg(REG_UNUSED, 10'd1023);
    run_phase(120, 0, 78);
    write_reg(REG_CPCL, 11'd0);
    write_reg(REG_UNUSED, 10'd1);
    run_phase(40, 7, 7);
    write_reg(REG_CPCL, 11'd1024);
    write_reg(REG_TOTAL, 48'd2);
    write_reg(REG_CELLS, 11'd1024);
    write_reg(REG_UNUSED, 10'd0);
    run_phase(40, 7, 7);

    // back to normal mode, both sides idling
    write_reg(REG_REV, 1'b0);
    write_reg(REG_CELLS, 11'd1);
    write_reg(REG_TOTAL, 48'd50);
    write_reg(REG_CPC, 48'd20);
    write_reg(REG_LAST, 48'd30);
    run_phase(120, 7, 7);

    if (errors == 0)
      $display("tb_binned_color_usage_map_core: PASS");
    else
      $display("tb_binned_color_usage_map_core: FAIL");
    $finish;
  end

endmodule

FILE: filelist.f
rtl/bcum_pkg.sv
rtl/bcum_if.sv
rtl/bcum_div.sv
rtl/bcum_dp.sv
rtl/bcum_ctrl.sv
rtl/binned_color_usage_map_core.sv
tb/sv/tb_binned_color_usage_map_core.sv
